// File: sv/drle_pkg.sv
// ----------------------------------------------------------------------------
// drle_pkg
// Types and constants shared by the delta run-length encoder modules.
// ----------------------------------------------------------------------------
package drle_pkg;

    localparam int SAMPLE_W = 14;
    localparam int DELTA_W  = 15;
    localparam int RUN_W    = 6;
    localparam int MAX_OUT  = 3;
    localparam int CNT_W    = 2;
    localparam int IDX_W    = 2;

    localparam logic [7:0]               MARK_VALID   = 8'h80;
    localparam logic [7:0]               MARK_WIDE    = 8'h40;
    localparam logic [RUN_W-1:0]         RUN_LIMIT    = 6'd63;
    localparam logic signed [DELTA_W-1:0] NARROW_BOUND = 15'sd63;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_sample;
        logic                       last_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } out_item_t;

    // Bytes caused by one input item, data[0] goes out first.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [CNT_W-1:0]        count;
    } enc_bytes_t;

endpackage

// File: sv/drle_encode.sv
// ----------------------------------------------------------------------------
// drle_encode
// Coder state and the single-pass logic that turns one sample into its bytes.
// ----------------------------------------------------------------------------
module drle_encode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  drle_pkg::in_item_t   item,
    output drle_pkg::enc_bytes_t enc
);

    logic signed [drle_pkg::SAMPLE_W-1:0] prev_value_reg, prev_value_next;
    logic signed [drle_pkg::DELTA_W-1:0]  prev_delta_reg, prev_delta_next;
    logic                                 wide_reg, wide_next;
    logic [drle_pkg::RUN_W-1:0]           run_reg, run_next;

    logic signed [drle_pkg::DELTA_W-1:0] delta;
    logic [15:0]                         sample16;
    logic                                narrow;
    logic                                mode_after;
    logic                                repeat_hit;
    logic [drle_pkg::RUN_W-1:0]          run_inc;
    logic                                close_run;
    logic                                mark;
    logic [drle_pkg::RUN_W-1:0]          mark_count;
    logic [7:0]                          marker;
    logic [7:0]                          dhi, dlo;

    always_comb begin
        sample16   = {{2{item.sample[drle_pkg::SAMPLE_W-1]}}, item.sample};
        delta      = {item.sample[drle_pkg::SAMPLE_W-1], item.sample}
                   - {prev_value_reg[drle_pkg::SAMPLE_W-1], prev_value_reg};
        narrow     = (delta > -drle_pkg::NARROW_BOUND) && (delta < drle_pkg::NARROW_BOUND);
        mode_after = !narrow;
        repeat_hit = (delta == prev_delta_reg);
        run_inc    = run_reg + 1'b1;
        close_run  = (run_inc == drle_pkg::RUN_LIMIT) || item.last_sample;
        mark_count = repeat_hit ? run_inc : run_reg;
        marker     = drle_pkg::MARK_VALID | (mode_after ? drle_pkg::MARK_WIDE : 8'h00)
                   | {2'b00, mark_count};
        mark       = (run_reg != '0) || (wide_reg != mode_after);
        dhi        = {1'b0, delta[14:8]};
        dlo        = mode_after ? delta[7:0] : {1'b0, delta[6:0]};

        enc             = '0;
        prev_value_next = prev_value_reg;
        prev_delta_next = prev_delta_reg;
        wide_next       = wide_reg;
        run_next        = run_reg;

        if (item.first_sample) begin
            enc.data[0]     = sample16[15:8];
            enc.data[1]     = sample16[7:0];
            enc.count       = 2'd2;
            prev_value_next = item.sample;
            prev_delta_next = '0;
            wide_next       = 1'b1;
            run_next        = '0;
        end else if (repeat_hit) begin
            prev_value_next = item.sample;
            if (close_run) begin
                enc.data[0] = marker;
                enc.count   = 2'd1;
                wide_next   = mode_after;
                run_next    = '0;
            end else begin
                run_next = run_inc;
            end
        end else begin
            prev_value_next = item.sample;
            prev_delta_next = delta;
            wide_next       = mode_after;
            run_next        = '0;
            // Marker, when present, leads; delta bytes follow.
            if (mark) begin
                enc.data[0] = marker;
                if (mode_after) begin
                    enc.data[1] = dhi;
                    enc.data[2] = dlo;
                    enc.count   = 2'd3;
                end else begin
                    enc.data[1] = dlo;
                    enc.count   = 2'd2;
                end
            end else begin
                if (mode_after) begin
                    enc.data[0] = dhi;
                    enc.data[1] = dlo;
                    enc.count   = 2'd2;
                end else begin
                    enc.data[0] = dlo;
                    enc.count   = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_value_reg <= '0;
            prev_delta_reg <= '0;
            wide_reg       <= 1'b1;
            run_reg        <= '0;
        end else if (take) begin
            prev_value_reg <= prev_value_next;
            prev_delta_reg <= prev_delta_next;
            wide_reg       <= wide_next;
            run_reg        <= run_next;
        end
    end

endmodule

// File: sv/drle_serialize.sv
// ----------------------------------------------------------------------------
// drle_serialize
// Result register holding the bytes of one item, sent one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module drle_serialize (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  drle_pkg::enc_bytes_t enc,
    output logic                 load_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output drle_pkg::out_item_t  m_item
);

    logic [drle_pkg::MAX_OUT-1:0][7:0] data_reg;
    logic [drle_pkg::CNT_W-1:0]        cnt_reg;
    logic [drle_pkg::IDX_W-1:0]        idx_reg;
    logic                              valid_reg;
    logic                              at_last;
    logic                              pop;

    assign at_last    = (idx_reg == cnt_reg - 1'b1);
    assign pop        = valid_reg && m_ready;
    assign load_ready = !valid_reg || (m_ready && at_last);

    assign m_valid             = valid_reg;
    assign m_item.out_byte     = data_reg[idx_reg];
    assign m_item.last_of_item = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load && load_ready) begin
            // Items that cause no byte leave the register empty.
            valid_reg <= (enc.count != '0);
            idx_reg   <= '0;
        end else if (pop) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            data_reg <= enc.data;
            cnt_reg  <= enc.count;
        end
    end

endmodule

// File: sv/delta_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// delta_run_length_encoder_top
// Delta run-length encoder: signed 14-bit samples in, coded bytes out.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_item carries one sample with its block
// flags; output channel m_valid/m_ready/m_item carries one byte per item,
// with last_of_item set on the final byte that a sample causes.
// A sample is held in the input register, is coded in a single pass
// into zero to three bytes, and these are registered in the byte
// register, whose current byte drives m_item.
// The byte register sends one byte per cycle while m_ready is high, so
// a sample's bytes leave one after another. The next sample is coded in
// the cycle the last byte of the previous one is taken.
// Reset clears the coder to wide mode, previous sample and delta zero, no
// open run, and empties both registers. When the receiver stalls, the
// current byte holds, the coded sample behind it waits in the input
// register, and s_ready drops once that register is full.
// ----------------------------------------------------------------------------
module delta_run_length_encoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  drle_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output drle_pkg::out_item_t m_item
);

    drle_pkg::in_item_t   in_item_reg;
    logic                 in_valid_reg;
    drle_pkg::enc_bytes_t enc;
    logic                 ser_ready;
    logic                 take;

    assign take    = in_valid_reg && ser_ready;
    assign s_ready = !in_valid_reg || ser_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    drle_encode u_encode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (in_item_reg),
        .enc     (enc)
    );

    drle_serialize u_serialize (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_valid_reg),
        .enc        (enc),
        .load_ready (ser_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
